// ===== hdl/cr3bp_state_derivative_unit_macros.svh =====
// ----------------------------------------------------------------------------
// CR3BP state derivative unit - assertion macros
// Shared concurrent assertion forms for the derivative pipeline.
// ----------------------------------------------------------------------------
`ifndef CR3BP_STATE_DERIVATIVE_UNIT_MACROS_SVH
`define CR3BP_STATE_DERIVATIVE_UNIT_MACROS_SVH

// same-cycle implication
`define CRD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/crd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_pkg
// Widths, latencies, register codes and shared types of the derivative unit.
// ----------------------------------------------------------------------------
package crd_pkg;

   localparam int DATA_W     = 48;
   localparam int FRAC_W     = 32;
   localparam int MU_W       = 32;
   localparam int MAG_W      = 48;
   localparam int SQ_W       = 96;
   localparam int ROOT_W     = 48;
   localparam int SQRT_LAT   = ROOT_W;
   localparam int DIV1_STEPS = 33;
   localparam int DIV2_STEPS = 65;
   localparam int DIV3_STEPS = 66;
   localparam int STEP_NUM   = DIV1_STEPS + DIV2_STEPS + DIV3_STEPS;
   localparam int GRAV_LAT   = STEP_NUM + 3;
   localparam int SIDE_LAT   = SQRT_LAT + GRAV_LAT;
   localparam int LIN_W      = 50;
   localparam int GRAV_W     = 68;
   localparam int ADDR_W     = 3;

   localparam logic        REG_MASS_RATIO   = 1'b0;
   localparam logic [31:0] MASS_RATIO_RESET = 32'd108578;

   typedef logic signed [DATA_W-1:0] data_type;

   // magnitudes and signs of the offsets that feed the gravity terms
   typedef struct packed {
      logic [MAG_W-1:0] d1;
      logic [MAG_W-1:0] d2;
      logic [MAG_W-1:0] y;
      logic [MAG_W-1:0] z;
      logic             n_d1;
      logic             n_d2;
      logic             n_y;
      logic             n_z;
   } mag_type;

   // values that ride alongside the long arithmetic
   typedef struct packed {
      logic [DATA_W-1:0] vx;
      logic [DATA_W-1:0] vy;
      logic [DATA_W-1:0] vz;
      logic [LIN_W-1:0]  lx;
      logic [LIN_W-1:0]  ly;
      logic              zero;
   } side_type;

endpackage

// ===== hdl/crd_channels_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd request / response channels
// Valid/ready channels carrying one state and one derivative per transfer.
// ----------------------------------------------------------------------------
interface crd_req_if;
   logic               valid;
   logic               ready;
   crd_pkg::data_type  pos_x;
   crd_pkg::data_type  pos_y;
   crd_pkg::data_type  pos_z;
   crd_pkg::data_type  vel_x;
   crd_pkg::data_type  vel_y;
   crd_pkg::data_type  vel_z;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface crd_rsp_if;
   logic               valid;
   logic               ready;
   crd_pkg::data_type  dpos_x;
   crd_pkg::data_type  dpos_y;
   crd_pkg::data_type  dpos_z;
   crd_pkg::data_type  accel_x;
   crd_pkg::data_type  accel_y;
   crd_pkg::data_type  accel_z;
   logic               range_error;

   modport source (output valid, dpos_x, dpos_y, dpos_z, accel_x, accel_y, accel_z,
                   range_error, input ready);
   modport sink   (input valid, dpos_x, dpos_y, dpos_z, accel_x, accel_y, accel_z,
                   range_error, output ready);
endinterface

// ===== hdl/crd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_sqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module crd_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [crd_pkg::SQ_W-1:0]    radicand,
   output logic [crd_pkg::ROOT_W-1:0]  root
);

   typedef struct packed {
      logic [crd_pkg::SQ_W-1:0]   rem;
      logic [crd_pkg::ROOT_W-1:0] root;
   } sq_type;

   sq_type st_ff [crd_pkg::ROOT_W];
   sq_type st_in [crd_pkg::ROOT_W];

   for (genvar k = 0; k < crd_pkg::ROOT_W; k++) begin : g_stage
      localparam int B = crd_pkg::ROOT_W - 1 - k;
      sq_type            src;
      logic [crd_pkg::SQ_W:0] trial;

      if (k == 0) begin : g_first
         assign src = '{rem: radicand, root: '0};
      end else begin : g_next
         assign src = st_ff[k-1];
      end

      // (r + 2^B)^2 - r^2, with the bits of r below B still clear
      assign trial = ((crd_pkg::SQ_W+1)'(src.root) << (B + 1))
                   + ((crd_pkg::SQ_W+1)'(1) << (2 * B));

      always_comb begin
         st_in[k] = src;
         if ({1'b0, src.rem} >= trial) begin
            st_in[k].rem  = crd_pkg::SQ_W'({1'b0, src.rem} - trial);
            st_in[k].root = src.root | (crd_pkg::ROOT_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign root = st_ff[crd_pkg::ROOT_W-1].root;

endmodule

// ===== hdl/crd_grav.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_grav
// One gravity term m*c/r^3: product, then three chained long divisions by r.
// ----------------------------------------------------------------------------
module crd_grav (
   input  logic                        clock,
   input  logic                        en,
   input  logic [crd_pkg::MU_W:0]      mass,
   input  logic [crd_pkg::MAG_W-1:0]   mag,
   input  logic                        neg,
   input  logic [crd_pkg::ROOT_W-1:0]  root,
   output logic [crd_pkg::GRAV_W-1:0]  term
);

   typedef struct packed {
      logic [47:0] rem;
      logic [65:0] num;
      logic [65:0] quo;
      logic [47:0] dvs;
      logic        neg;
      logic        cap;
   } div_type;

   function automatic div_type div_step(div_type s);
      div_type     o;
      logic [48:0] trial;
      o     = s;
      trial = {s.rem, s.num[65]};
      if (trial >= {1'b0, s.dvs}) begin
         o.rem = 48'(trial - {1'b0, s.dvs});
         o.quo = {s.quo[64:0], 1'b1};
      end else begin
         o.rem = trial[47:0];
         o.quo = {s.quo[64:0], 1'b0};
      end
      o.num = {s.num[64:0], 1'b0};
      return o;
   endfunction

   // product m*|c|, split to keep the multipliers narrow
   logic [64:0] pl_ff;
   logic [48:0] ph_ff;
   logic        neg0_ff, neg1_ff;
   logic [47:0] root0_ff, root1_ff;
   logic [80:0] n1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff    <= 65'(mass * mag[31:0]);
         ph_ff    <= 49'(mass * mag[47:32]);
         neg0_ff  <= neg;
         root0_ff <= root;
         n1_ff    <= {16'b0, pl_ff} + {ph_ff, 32'b0};
         neg1_ff  <= neg0_ff;
         root1_ff <= root0_ff;
      end
   end

   div_type st_ff [crd_pkg::STEP_NUM];
   div_type st_in [crd_pkg::STEP_NUM];

   for (genvar k = 0; k < crd_pkg::STEP_NUM; k++) begin : g_step
      div_type src;

      if (k == 0) begin : g_first
         // v1 = m*|c| / r; upper part already below r
         always_comb begin
            src     = '0;
            src.rem = n1_ff[80:33];
            src.num = {n1_ff[32:0], 33'b0};
            src.dvs = root1_ff;
            src.neg = neg1_ff;
         end
      end else if (k == crd_pkg::DIV1_STEPS) begin : g_second
         // v2 = v1*2^F / r
         always_comb begin
            src     = st_ff[k-1];
            src.rem = '0;
            src.num = {st_ff[k-1].quo[32:0], 33'b0};
            src.quo = '0;
         end
      end else if (k == crd_pkg::DIV1_STEPS + crd_pkg::DIV2_STEPS) begin : g_third
         // t = v2*2^F / r, held at 2^66 once the top part reaches r
         always_comb begin
            src     = st_ff[k-1];
            src.cap = {17'b0, st_ff[k-1].quo[64:34]} >= st_ff[k-1].dvs;
            src.rem = {17'b0, st_ff[k-1].quo[64:34]};
            src.num = {st_ff[k-1].quo[33:0], 32'b0};
            src.quo = '0;
         end
      end else begin : g_mid
         assign src = st_ff[k-1];
      end

      assign st_in[k] = div_step(src);

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   div_type                     last;
   logic [crd_pkg::GRAV_W-1:0]  mag_t;
   logic [crd_pkg::GRAV_W-1:0]  term_ff, term_in;

   assign last  = st_ff[crd_pkg::STEP_NUM-1];
   assign mag_t = last.cap ? (crd_pkg::GRAV_W'(1) << 66) : {2'b0, last.quo};

   always_comb begin
      term_in = last.neg ? (~mag_t + crd_pkg::GRAV_W'(1)) : mag_t;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

// ===== hdl/cr3bp_state_derivative_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one state per cycle, except while a result waits in the output register
//   and the sink is not taking it. The path runs through the 48-stage root pipelines
//   and the 167-stage gravity pipelines (164 one-bit division steps in each).
// Reset (synchronous, active high): all valid bits cleared, mass_ratio back
//   to 108578. No clearing pass; the block takes a transfer the cycle after.
// ----------------------------------------------------------------------------
// cr3bp_state_derivative_unit
// Rotating-frame CR3BP equations of motion in Q15.32, fully pipelined.
// ----------------------------------------------------------------------------
`include "cr3bp_state_derivative_unit_macros.svh"

module cr3bp_state_derivative_unit (
   input  logic                         clock,
   input  logic                         reset,
   crd_req_if.sink                      req,
   crd_rsp_if.source                    rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [crd_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam logic [32:0] ONE33   = 33'(1) << crd_pkg::FRAC_W;
   localparam logic [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
   localparam logic [47:0] ACC_MIN = {1'b1, 47'b0};

   function automatic logic [47:0] abs50(logic [49:0] v);
      logic [49:0] a;
      a = v[49] ? (~v + 50'd1) : v;
      return a[47:0];
   endfunction

   function automatic logic [47:0] abs48(logic [47:0] v);
      return v[47] ? (~v + 48'd1) : v;
   endfunction

   // {flag, value}: clamp a 70-bit sum to the signed 48-bit range
   function automatic logic [48:0] clamp70(logic [69:0] v);
      logic [48:0] r;
      if (!v[69] && (v[68:47] != '0)) begin
         r = {1'b1, ACC_MAX};
      end else if (v[69] && (v[68:47] != '1)) begin
         r = {1'b1, ACC_MIN};
      end else begin
         r = {1'b0, v[47:0]};
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- CSR
   logic [31:0] mass_ratio_ff, mass_ratio_in;
   logic        csr_wr;

   assign csr_wr = psel && penable && pwrite
                && (paddr[crd_pkg::ADDR_W-1] == crd_pkg::REG_MASS_RATIO);

   always_comb begin
      mass_ratio_in = mass_ratio_ff;
      if (csr_wr) begin
         mass_ratio_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ratio_ff <= crd_pkg::MASS_RATIO_RESET;
      end else begin
         mass_ratio_ff <= mass_ratio_in;
      end
   end

   assign prdata = (paddr[crd_pkg::ADDR_W-1] == crd_pkg::REG_MASS_RATIO) ? mass_ratio_ff : '0;
   assign pready = 1'b1;

   // mu and 1-mu; the user must see that they are only changed while the pipe is empty
   logic [32:0] mu33, omu33;
   assign mu33  = {1'b0, mass_ratio_ff};
   assign omu33 = ONE33 - mu33;

   // ------------------------------------------------------ pipe control
   // Single advance enable: the whole pipe holds while the output
   // register has a result waiting and the sink is not taking it.
   logic en, vo_ff;
   assign en        = !vo_ff || rsp.ready;
   assign req.ready = en;

   // --------------------------------------------------- stage 1: capture
   logic        v1_ff;
   logic [47:0] x1_ff, y1_ff, z1_ff, vx1_ff, vy1_ff, vz1_ff;

   // --------------------------------------------- stage 2: offsets, |.|
   logic              v2_ff;
   crd_pkg::mag_type  mag2_ff, mag2_in;
   crd_pkg::side_type side2_ff, side2_in;
   logic [49:0]       d1_w, d2_w;

   always_comb begin
      d1_w = {{2{x1_ff[47]}}, x1_ff} + {17'b0, mu33};
      d2_w = d1_w - {17'b0, ONE33};
      mag2_in.d1   = abs50(d1_w);
      mag2_in.d2   = abs50(d2_w);
      mag2_in.y    = abs48(y1_ff);
      mag2_in.z    = abs48(z1_ff);
      mag2_in.n_d1 = d1_w[49];
      mag2_in.n_d2 = d2_w[49];
      mag2_in.n_y  = y1_ff[47];
      mag2_in.n_z  = z1_ff[47];
      side2_in.vx   = vx1_ff;
      side2_in.vy   = vy1_ff;
      side2_in.vz   = vz1_ff;
      // Coriolis plus centrifugal parts
      side2_in.lx   = {vy1_ff[47], vy1_ff, 1'b0} + {{2{x1_ff[47]}}, x1_ff};
      side2_in.ly   = {{2{y1_ff[47]}}, y1_ff} - {vx1_ff[47], vx1_ff, 1'b0};
      side2_in.zero = 1'b0;
   end

   // ------------------------------------------ stage 3: partial squares
   logic              v3_ff;
   crd_pkg::mag_type  mag3_ff;
   crd_pkg::side_type side3_ff;
   logic [31:0]       hh_ff [4];
   logic [47:0]       hl_ff [4];
   logic [63:0]       ll_ff [4];
   logic [47:0]       mv [4];

   assign mv[0] = mag2_ff.d1;
   assign mv[1] = mag2_ff.d2;
   assign mv[2] = mag2_ff.y;
   assign mv[3] = mag2_ff.z;

   // ----------------------------------------------- stage 4: squares
   logic              v4_ff;
   crd_pkg::mag_type  mag4_ff;
   crd_pkg::side_type side4_ff;
   logic [95:0]       sq_ff [4];

   // ------------------------------------------ stage 5: sums of squares
   logic              v5_ff;
   crd_pkg::mag_type  mag5_ff;
   crd_pkg::side_type side5_ff, side5_in;
   logic [95:0]       s1_ff, s2_ff;

   always_comb begin
      side5_in      = side4_ff;
      // a zero distance to either primary
      side5_in.zero = ((sq_ff[0] | sq_ff[2] | sq_ff[3]) == '0)
                   || ((sq_ff[1] | sq_ff[2] | sq_ff[3]) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= req.pos_x;
         y1_ff    <= req.pos_y;
         z1_ff    <= req.pos_z;
         vx1_ff   <= req.vel_x;
         vy1_ff   <= req.vel_y;
         vz1_ff   <= req.vel_z;
         mag2_ff  <= mag2_in;
         side2_ff <= side2_in;
         for (int i = 0; i < 4; i++) begin
            hh_ff[i] <= mv[i][47:32] * mv[i][47:32];
            hl_ff[i] <= mv[i][47:32] * mv[i][31:0];
            ll_ff[i] <= mv[i][31:0] * mv[i][31:0];
            sq_ff[i] <= {hh_ff[i], 64'b0} + {15'b0, hl_ff[i], 33'b0} + {32'b0, ll_ff[i]};
         end
         mag3_ff  <= mag2_ff;
         side3_ff <= side2_ff;
         mag4_ff  <= mag3_ff;
         side4_ff <= side3_ff;
         s1_ff    <= sq_ff[0] + sq_ff[2] + sq_ff[3];
         s2_ff    <= sq_ff[1] + sq_ff[2] + sq_ff[3];
         mag5_ff  <= mag4_ff;
         side5_ff <= side5_in;
      end
   end

   // ------------------------------------------------- distance roots
   logic [crd_pkg::ROOT_W-1:0] root1, root2;

   crd_sqrt u_sqrt1 (.clock(clock), .en(en), .radicand(s1_ff), .root(root1));
   crd_sqrt u_sqrt2 (.clock(clock), .en(en), .radicand(s2_ff), .root(root2));

   // magnitudes wait alongside the roots
   crd_pkg::mag_type mag_dl_ff [crd_pkg::SQRT_LAT];
   crd_pkg::mag_type mg;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_dl_ff[0] <= mag5_ff;
         for (int k = 1; k < crd_pkg::SQRT_LAT; k++) begin
            mag_dl_ff[k] <= mag_dl_ff[k-1];
         end
      end
   end

   assign mg = mag_dl_ff[crd_pkg::SQRT_LAT-1];

   // --------------------------------------------------- gravity terms
   // 0/1: x terms, 2/3: y terms, 4/5: z terms; even = 1-mu, odd = mu
   logic [crd_pkg::GRAV_W-1:0] gterm [6];

   crd_grav u_grav_x1 (.clock(clock), .en(en), .mass(omu33), .mag(mg.d1), .neg(mg.n_d1),
                       .root(root1), .term(gterm[0]));
   crd_grav u_grav_x2 (.clock(clock), .en(en), .mass(mu33), .mag(mg.d2), .neg(mg.n_d2),
                       .root(root2), .term(gterm[1]));
   crd_grav u_grav_y1 (.clock(clock), .en(en), .mass(omu33), .mag(mg.y), .neg(mg.n_y),
                       .root(root1), .term(gterm[2]));
   crd_grav u_grav_y2 (.clock(clock), .en(en), .mass(mu33), .mag(mg.y), .neg(mg.n_y),
                       .root(root2), .term(gterm[3]));
   crd_grav u_grav_z1 (.clock(clock), .en(en), .mass(omu33), .mag(mg.z), .neg(mg.n_z),
                       .root(root1), .term(gterm[4]));
   crd_grav u_grav_z2 (.clock(clock), .en(en), .mass(mu33), .mag(mg.z), .neg(mg.n_z),
                       .root(root2), .term(gterm[5]));

   // side values and valid bits wait through roots and gravity
   crd_pkg::side_type           side_dl_ff [crd_pkg::SIDE_LAT];
   logic [crd_pkg::SIDE_LAT-1:0] vl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= '0;
      end else if (en) begin
         vl_ff <= {vl_ff[crd_pkg::SIDE_LAT-2:0], v5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_dl_ff[0] <= side5_ff;
         for (int k = 1; k < crd_pkg::SIDE_LAT; k++) begin
            side_dl_ff[k] <= side_dl_ff[k-1];
         end
      end
   end

   // ------------------------------------------ sum, subtract, saturate
   logic              vs_ff, va_ff;
   crd_pkg::side_type side_s_ff, side_a_ff;
   logic [68:0]       gs_ff [3];
   logic [69:0]       acc_ff [3];
   logic [48:0]       cx, cy, cz;
   logic [47:0]       ax_in, ay_in, az_in;
   logic              err_in;
   logic [47:0]       dpx_ff, dpy_ff, dpz_ff, ax_ff, ay_ff, az_ff;
   logic              err_ff;

   always_comb begin
      cx = clamp70(acc_ff[0]);
      cy = clamp70(acc_ff[1]);
      cz = clamp70(acc_ff[2]);
      if (side_a_ff.zero) begin
         ax_in  = ACC_MAX;
         ay_in  = ACC_MAX;
         az_in  = ACC_MAX;
         err_in = 1'b1;
      end else begin
         ax_in  = cx[47:0];
         ay_in  = cy[47:0];
         az_in  = cz[47:0];
         err_in = cx[48] || cy[48] || cz[48];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
         va_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         vs_ff <= vl_ff[crd_pkg::SIDE_LAT-1];
         va_ff <= vs_ff;
         vo_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            gs_ff[i] <= {gterm[2*i][67], gterm[2*i]} + {gterm[2*i+1][67], gterm[2*i+1]};
         end
         side_s_ff <= side_dl_ff[crd_pkg::SIDE_LAT-1];
         acc_ff[0] <= {{20{side_s_ff.lx[49]}}, side_s_ff.lx} - {gs_ff[0][68], gs_ff[0]};
         acc_ff[1] <= {{20{side_s_ff.ly[49]}}, side_s_ff.ly} - {gs_ff[1][68], gs_ff[1]};
         acc_ff[2] <= 70'd0 - {gs_ff[2][68], gs_ff[2]};
         side_a_ff <= side_s_ff;
         dpx_ff    <= side_a_ff.vx;
         dpy_ff    <= side_a_ff.vy;
         dpz_ff    <= side_a_ff.vz;
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         az_ff     <= az_in;
         err_ff    <= err_in;
      end
   end

   assign rsp.valid       = vo_ff;
   assign rsp.dpos_x      = dpx_ff;
   assign rsp.dpos_y      = dpy_ff;
   assign rsp.dpos_z      = dpz_ff;
   assign rsp.accel_x     = ax_ff;
   assign rsp.accel_y     = ay_ff;
   assign rsp.accel_z     = az_ff;
   assign rsp.range_error = err_ff;

   // ------------------------------------------------------- assertions
   `CRD_ASSERT_NEXT(a_accept_enters, clock, reset, req.valid && req.ready, v1_ff, "accepted transfer missing from first stage")
   `CRD_ASSERT_NEXT(a_stall_freezes, clock, reset, !en, $stable(vl_ff) && $stable(v5_ff), "valid line moved during stall")
   `CRD_ASSERT_IMPL(a_backpressure, clock, reset, rsp.valid && !rsp.ready, !req.ready, "input taken while result held")
   `CRD_ASSERT_NEXT(a_zero_saturates, clock, reset, en && va_ff && side_a_ff.zero, rsp.valid && rsp.range_error && (rsp.accel_x == ACC_MAX), "zero distance not saturated")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - CR3BP state derivative unit testbench
// Streams rotating-frame states through the unit under several mass ratios,
// with random idling on both channels, and compares every derivative field
// against a bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      crd_pkg::data_type px, py, pz, vx, vy, vz;
   } state_type;

   typedef struct {
      crd_pkg::data_type dx, dy, dz, ax, ay, az;
      logic              rerr;
   } deriv_type;

   localparam logic signed [127:0] ACC_MAX = (128'sd1 <<< (crd_pkg::DATA_W - 1)) - 1;
   localparam logic signed [127:0] ACC_MIN = -(128'sd1 <<< (crd_pkg::DATA_W - 1));
   localparam logic [127:0]        TERM_CAP = 128'd1 << 66;
   localparam int                  DUT_LAT  = 222;

   // -------------------------------------------------------------------------
   // scoreboard: predicts derivatives for accepted states, checks results
   // -------------------------------------------------------------------------
   class derivative_scoreboard;
      logic [31:0] mu_reg;
      deriv_type   pending[$];
      int          errors;

      function new();
         mu_reg = crd_pkg::MASS_RATIO_RESET;
         errors = 0;
      endfunction

      function logic [63:0] floor_root(logic [127:0] s);
         logic [63:0] r, t;
         r = 0;
         for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= s) r = t;
         end
         return r;
      endfunction

      // m*c/r^3 by three truncating divides, capped when too large
      function logic signed [127:0] grav_term(logic [63:0] m, logic signed [63:0] c,
                                              logic [63:0] r);
         logic [63:0]  cm, v1;
         logic [127:0] v2, t;
         cm = (c < 0) ? -c : c;
         v1 = 64'((128'(m) * 128'(cm)) / 128'(r));
         v2 = (128'(v1) << crd_pkg::FRAC_W) / 128'(r);
         if (v2 >= (128'd1 << 80)) t = TERM_CAP;
         else begin
            t = (v2 << crd_pkg::FRAC_W) / 128'(r);
            if (t >= TERM_CAP) t = TERM_CAP;
         end
         return (c < 0) ? -$signed(t) : $signed(t);
      endfunction

      function crd_pkg::data_type clamp48(logic signed [127:0] v, inout logic flag);
         if (v > ACC_MAX) begin
            flag = 1'b1;
            return crd_pkg::data_type'(ACC_MAX[crd_pkg::DATA_W-1:0]);
         end
         if (v < ACC_MIN) begin
            flag = 1'b1;
            return crd_pkg::data_type'(ACC_MIN[crd_pkg::DATA_W-1:0]);
         end
         return crd_pkg::data_type'(v[crd_pkg::DATA_W-1:0]);
      endfunction

      function void note_state(state_type s);
         logic signed [63:0]  x, y, z, d1, d2;
         logic [63:0]         mu, omu, md1, md2, my, mz, r1, r2;
         logic [127:0]        yz;
         logic signed [127:0] wx, wy, wvx, wvy, ax, ay, az;
         logic                flag;
         deriv_type           e;
         x = s.px; y = s.py; z = s.pz;
         mu  = 64'(mu_reg);
         omu = (64'd1 << crd_pkg::FRAC_W) - mu;
         d1 = x + $signed(mu);
         d2 = d1 - $signed(64'd1 << crd_pkg::FRAC_W);
         md1 = (d1 < 0) ? -d1 : d1;
         md2 = (d2 < 0) ? -d2 : d2;
         my  = (y < 0) ? -y : y;
         mz  = (z < 0) ? -z : z;
         yz = 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
         r1 = floor_root(128'(md1) * 128'(md1) + yz);
         r2 = floor_root(128'(md2) * 128'(md2) + yz);
         e.dx = s.vx; e.dy = s.vy; e.dz = s.vz;
         flag = 1'b0;
         if (r1 == 0 || r2 == 0) begin
            // state on top of a primary: all accelerations pinned high
            e.ax = crd_pkg::data_type'(ACC_MAX[crd_pkg::DATA_W-1:0]);
            e.ay = e.ax;
            e.az = e.ax;
            e.rerr = 1'b1;
         end else begin
            wx = x; wy = y; wvx = s.vx; wvy = s.vy;
            ax = wvy + wvy + wx - (grav_term(omu, d1, r1) + grav_term(mu, d2, r2));
            ay = wy - (wvx + wvx) - (grav_term(omu, y, r1) + grav_term(mu, y, r2));
            az = -(grav_term(omu, z, r1) + grav_term(mu, z, r2));
            e.ax = clamp48(ax, flag);
            e.ay = clamp48(ay, flag);
            e.az = clamp48(az, flag);
            e.rerr = flag;
         end
         pending.push_back(e);
      endfunction

      function void check_deriv(deriv_type a);
         deriv_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected derivative transfer", $realtime);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.dx !== e.dx) begin
            $display("%0t: dpos_x exp %h got %h", $realtime, e.dx, a.dx); errors++;
         end
         if (a.dy !== e.dy) begin
            $display("%0t: dpos_y exp %h got %h", $realtime, e.dy, a.dy); errors++;
         end
         if (a.dz !== e.dz) begin
            $display("%0t: dpos_z exp %h got %h", $realtime, e.dz, a.dz); errors++;
         end
         if (a.ax !== e.ax) begin
            $display("%0t: accel_x exp %h got %h", $realtime, e.ax, a.ax); errors++;
         end
         if (a.ay !== e.ay) begin
            $display("%0t: accel_y exp %h got %h", $realtime, e.ay, a.ay); errors++;
         end
         if (a.az !== e.az) begin
            $display("%0t: accel_z exp %h got %h", $realtime, e.az, a.az); errors++;
         end
         if (a.rerr !== e.rerr) begin
            $display("%0t: range_error exp %b got %b", $realtime, e.rerr, a.rerr); errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [crd_pkg::ADDR_W-1:0]  paddr = '0;
   logic [31:0]                 pwdata = '0;
   logic [31:0]                 prdata;
   logic                        pready;
   bit                          quiet = 0;   // no idling in the closing phase

   crd_req_if req ();
   crd_rsp_if rsp ();

   derivative_scoreboard sb = new();

   cr3bp_state_derivative_unit dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.pos_x = '0; req.pos_y = '0; req.pos_z = '0;
      req.vel_x = '0; req.vel_y = '0; req.vel_z = '0;
      rsp.ready = 1'b0;
   end

   // result side: random stall bursts, checked at the rising edge
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp.ready = 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall = $urandom_range(1, 13) - 1;
            rsp.ready = 1'b0;
         end else begin
            rsp.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      deriv_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.dx = rsp.dpos_x;  got.dy = rsp.dpos_y;  got.dz = rsp.dpos_z;
         got.ax = rsp.accel_x; got.ay = rsp.accel_y; got.az = rsp.accel_z;
         got.rerr = rsp.range_error;
         sb.check_deriv(got);
      end
   end

   // register write in a setup phase and an access phase; the scoreboard follows once it lands
   task automatic csr_write(logic [31:0] value);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
      paddr = crd_pkg::ADDR_W'(4 * crd_pkg::REG_MASS_RATIO);
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      sb.mu_reg = value;
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // one state transfer, with an optional idle burst ahead of it
   task automatic send_state(state_type s);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 15) == 0) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req.valid = 1'b1;
      req.pos_x = s.px; req.pos_y = s.py; req.pos_z = s.pz;
      req.vel_x = s.vx; req.vel_y = s.vy; req.vel_z = s.vz;
      do @(posedge clock); while (!req.ready);
      sb.note_state(s);
   endtask

   task automatic go_idle();
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   function automatic crd_pkg::data_type any48();
      return crd_pkg::data_type'({$urandom, $urandom});
   endfunction

   // coordinate mix: mostly orbital scale, some near a primary, some full range
   function automatic crd_pkg::data_type coord(int kind);
      crd_pkg::data_type v;
      case (kind)
         0: v = crd_pkg::data_type'($signed(34'({$urandom, $urandom})));
         1: v = crd_pkg::data_type'($signed(20'($urandom)));
         default: v = any48();
      endcase
      return v;
   endfunction

   function automatic state_type rand_state();
      state_type s;
      int        k;
      k = $urandom_range(0, 9);
      if (k < 6) begin
         s.px = coord(0); s.py = coord(0); s.pz = coord(0);
      end else if (k < 8) begin
         // close to one primary or the other
         s.px = ($urandom_range(0, 1) ? -crd_pkg::data_type'(sb.mu_reg)
                 : crd_pkg::data_type'(64'd1 << crd_pkg::FRAC_W)
                   - crd_pkg::data_type'(sb.mu_reg)) + coord(1);
         s.py = ($urandom_range(0, 3) == 0) ? '0 : coord(1);
         s.pz = ($urandom_range(0, 3) == 0) ? '0 : coord(1);
      end else begin
         s.px = coord(2); s.py = coord(2); s.pz = coord(2);
      end
      s.vx = ($urandom_range(0, 4) == 0) ? coord(2) : coord(0);
      s.vy = ($urandom_range(0, 4) == 0) ? coord(2) : coord(0);
      s.vz = ($urandom_range(0, 4) == 0) ? coord(2) : coord(0);
      return s;
   endfunction

   task automatic directed_states();
      state_type          s;
      crd_pkg::data_type  mx, mn, one, mu;
      mx  = crd_pkg::data_type'(ACC_MAX[crd_pkg::DATA_W-1:0]);
      mn  = crd_pkg::data_type'(ACC_MIN[crd_pkg::DATA_W-1:0]);
      one = crd_pkg::data_type'(64'd1 << crd_pkg::FRAC_W);
      mu  = crd_pkg::data_type'(sb.mu_reg);
      s = '{default: '0};                       send_state(s);
      s = '{mx, mx, mx, mx, mx, mx};            send_state(s);
      s = '{mn, mn, mn, mn, mn, mn};            send_state(s);
      s = '{mx, mn, mx, mn, mx, mn};            send_state(s);
      s = '{mn, mx, mn, mx, mn, mx};            send_state(s);
      // on the larger primary, then on the smaller one
      s = '{-mu, 0, 0, one, -one, one};         send_state(s);
      s = '{one - mu, 0, 0, -one, one, 0};      send_state(s);
      // one raw unit away from each primary
      s = '{-mu + 1, 0, 0, 0, 0, 0};            send_state(s);
      s = '{one - mu, 1, 0, 0, 0, 0};           send_state(s);
      s = '{-mu, 0, -1, 0, 0, 0};               send_state(s);
      // ordinary orbital states
      s = '{one >>> 1, one >>> 2, one >>> 3, one, one, 0};  send_state(s);
      s = '{-(one <<< 1), one, -one, -one, 0, one};         send_state(s);
      s = '{one, one, one, mx, mn, 0};                      send_state(s);
      s = '{0, mx, 0, 0, 0, 0};                             send_state(s);
      s = '{0, 0, mn, 0, 0, 0};                             send_state(s);
   endtask

   initial begin
      logic [31:0] mu_plan[5];
      mu_plan = '{crd_pkg::MASS_RATIO_RESET, 32'd0, 32'h8000_0000, 32'd0,
                  crd_pkg::MASS_RATIO_RESET};
      mu_plan[3] = $urandom_range(1, 32'h7FFF_FFFF);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            go_idle();
            wait_drained();
            repeat (DUT_LAT) @(posedge clock);
            csr_write(mu_plan[ph]);
         end
         if (ph == 4) quiet = 1;
         if (ph == 0 || ph == 2) directed_states();
         for (int i = 0; i < 340; i++) begin
            // hold the stream until the pipeline has emptied
            if (ph == 1 && i == 170) begin
               go_idle();
               wait_drained();
            end
            send_state(rand_state());
         end
      end
      go_idle();
      wait_drained();
      repeat (DUT_LAT + 20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== cr3bp_state_derivative_unit.f =====
+incdir+hdl
hdl/crd_pkg.sv
hdl/crd_channels_if.sv
hdl/crd_sqrt.sv
hdl/crd_grav.sv
hdl/cr3bp_state_derivative_unit.sv
tb/tb.sv
